### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising edge of clk.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds at a rising edge of clk.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)

`endif

`endif

### hdl/vtpg_pkg.sv
// ---------------------------------------------------------------------------
// vtpg_pkg
// Shared constants and types of the video test pattern generator.
// ---------------------------------------------------------------------------
package vtpg_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W  = 11;   // frame size registers
  localparam int POS_W  = 10;   // column and row counters
  localparam int PIX_W  = 8;    // luma / chroma
  localparam int DVD_W  = 20;   // divider dividend and quotient
  localparam int DCNT_W = 5;    // divider step counter

  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(DVD_W);

  localparam logic [PIX_W-1:0] CHROMA_VAL = 8'h80;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd352;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd288;
  localparam logic [DIM_W-1:0] DIM_MIN    = 11'd2;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // raster position handed to the setup sequencer
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } pos_t;

  // setup sequencer to raster: strobes and step / start values
  typedef struct packed {
    logic             busy;
    logic             load;
    logic [PIX_W-1:0] ramp_step_q;
    logic [DIM_W-1:0] ramp_step_r;
    logic [POS_W-1:0] diag_step_q;
    logic [DIM_W-1:0] diag_step_r;
    logic [PIX_W-1:0] ramp_q;
    logic [DIM_W-1:0] ramp_r;
    logic [DIM_W-1:0] diag_q;
    logic [DIM_W-1:0] diag_r;
  } init_ctrl_t;

endpackage

### hdl/video_test_pattern_generator_top.sv
// ---------------------------------------------------------------------------
// video_test_pattern_generator_top
// Raster-order YUV422 test pattern source with exact integer ramp/diagonals.
// ---------------------------------------------------------------------------
// Usage:
//   Each transfer on the in_ channel (in_valid && in_ready) requests one
//   pixel; in_restart = 1 moves the raster to column 0, row 0 first.
//   The pixel leaves on the out_ channel in the cycle after its input transfer,
//   as luma, chroma (always 0x80), line_end and frame_end.
//   Throughput is one pixel per cycle: the output register frees up in the
//   same cycle its pixel is taken, so input and output transfers can occur
//   on every clock while out_ready stays high and no setup pass runs.
//   When the receiver stalls (out_ready low with a pixel held), in_ready
//   drops and the held pixel stays unchanged.
//   The cfg_ channel writes frame_width (index 0) or frame_height (index 1);
//   sizes are clamped to 2..1024. cfg_ready is always high. A position left
//   outside a shrunk frame is folded back when the next pixel is taken.
//   After reset and after every configuration write a setup pass runs
//   (an entry state, four divisions on the shared restoring divider and a
//   load state); in_ready stays low meanwhile.
//   Reset (synchronous, rst_n low) restores 352 x 288 and the origin.
// ---------------------------------------------------------------------------
module video_test_pattern_generator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // pixel request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_restart,
  // pixel channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vtpg_pkg::PIX_W-1:0]  out_luma,
  output logic [vtpg_pkg::PIX_W-1:0]  out_chroma,
  output logic                        out_line_end,
  output logic                        out_frame_end,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [vtpg_pkg::DIM_W-1:0]  cfg_data
);

  logic [vtpg_pkg::DIM_W-1:0] width_r, height_r;
  logic [vtpg_pkg::DIM_W-1:0] width_eff, height_eff;
  logic                       cfg_wr;
  vtpg_pkg::init_ctrl_t       init_ctrl;
  vtpg_pkg::pos_t             pos;

  // every write is taken at once
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // hold the raw register values; clamp on the way out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= vtpg_pkg::WIDTH_RST;
      height_r <= vtpg_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        vtpg_pkg::CFG_WIDTH:  width_r  <= cfg_data;
        vtpg_pkg::CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r < vtpg_pkg::DIM_MIN) begin
      width_eff = vtpg_pkg::DIM_MIN;
    end else if (width_r > vtpg_pkg::DIM_W'(vtpg_pkg::MAX_WIDTH)) begin
      width_eff = vtpg_pkg::DIM_W'(vtpg_pkg::MAX_WIDTH);
    end else begin
      width_eff = width_r;
    end
    if (height_r < vtpg_pkg::DIM_MIN) begin
      height_eff = vtpg_pkg::DIM_MIN;
    end else if (height_r > vtpg_pkg::DIM_W'(vtpg_pkg::MAX_HEIGHT)) begin
      height_eff = vtpg_pkg::DIM_W'(vtpg_pkg::MAX_HEIGHT);
    end else begin
      height_eff = height_r;
    end
  end

  // setup pass: derive steps and start values for the folded position
  vtpg_init u_init (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .width  (width_eff),
    .height (height_eff),
    .pos    (pos),
    .ctrl   (init_ctrl)
  );

  // per-pixel datapath and output register
  vtpg_raster u_raster (
    .clk           (clk),
    .rst_n         (rst_n),
    .width         (width_eff),
    .height        (height_eff),
    .init_i        (init_ctrl),
    .pos           (pos),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_luma      (out_luma),
    .out_line_end  (out_line_end),
    .out_frame_end (out_frame_end)
  );

  assign out_chroma = vtpg_pkg::CHROMA_VAL;

endmodule

### hdl/vtpg_div.sv
// ---------------------------------------------------------------------------
// vtpg_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module vtpg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [vtpg_pkg::DVD_W-1:0]  dividend,
  input  logic [vtpg_pkg::DIM_W-1:0]  divisor,
  output logic                        done,
  output logic [vtpg_pkg::DVD_W-1:0]  quotient,
  output logic [vtpg_pkg::DIM_W-1:0]  remainder
);

  logic [vtpg_pkg::DCNT_W-1:0] cnt_r;
  logic                        done_r;
  logic [vtpg_pkg::DVD_W-1:0]  quo_r;
  logic [vtpg_pkg::DIM_W-1:0]  rem_r;
  logic [vtpg_pkg::DIM_W:0]    trial;
  logic [vtpg_pkg::DIM_W:0]    diff;
  logic                        ge;
  logic [vtpg_pkg::DIM_W-1:0]  rem_nxt;

  assign trial   = {rem_r, quo_r[vtpg_pkg::DVD_W-1]};
  assign ge      = trial >= {1'b0, divisor};
  assign diff    = trial - {1'b0, divisor};
  assign rem_nxt = ge ? diff[vtpg_pkg::DIM_W-1:0] : trial[vtpg_pkg::DIM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= vtpg_pkg::DIV_STEPS;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == vtpg_pkg::DCNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[vtpg_pkg::DVD_W-2:0], ge};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### hdl/vtpg_init.sv
// ---------------------------------------------------------------------------
// vtpg_init
// Setup sequencer: after reset or a size change, derive ramp and diagonal
// steps and start values for the folded position by division.
// ---------------------------------------------------------------------------
module vtpg_init (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr,
  input  logic [vtpg_pkg::DIM_W-1:0]  width,
  input  logic [vtpg_pkg::DIM_W-1:0]  height,
  input  vtpg_pkg::pos_t              pos,
  output vtpg_pkg::init_ctrl_t        ctrl
);

  typedef enum logic [6:0] {
    ST_NORM  = 7'b0000001,
    ST_RSTEP = 7'b0000010,
    ST_DSTEP = 7'b0000100,
    ST_RAMP  = 7'b0001000,
    ST_DIAG  = 7'b0010000,
    ST_LOAD  = 7'b0100000,
    ST_RUN   = 7'b1000000
  } init_state_t;

  init_state_t                 state_r, state_nxt;
  logic                        launched_r, launched_nxt;
  logic                        div_state;
  logic                        div_start;
  logic                        div_done;
  logic                        take;
  logic [vtpg_pkg::DVD_W-1:0]  dvd;
  logic [vtpg_pkg::DIM_W-1:0]  dvs;
  logic [vtpg_pkg::DVD_W-1:0]  quo;
  logic [vtpg_pkg::DIM_W-1:0]  rem;
  logic [vtpg_pkg::DVD_W:0]    prod;

  logic [vtpg_pkg::PIX_W-1:0]  rs_q_r;
  logic [vtpg_pkg::DIM_W-1:0]  rs_r_r;
  logic [vtpg_pkg::POS_W-1:0]  ds_q_r;
  logic [vtpg_pkg::DIM_W-1:0]  ds_r_r;
  logic [vtpg_pkg::PIX_W-1:0]  rq_r;
  logic [vtpg_pkg::DIM_W-1:0]  rr_r;
  logic [vtpg_pkg::DIM_W-1:0]  dq_r;
  logic [vtpg_pkg::DIM_W-1:0]  dr_r;

  // row * width stays below 2^20 for the supported sizes
  assign prod = {{(vtpg_pkg::DIM_W){1'b0}}, pos.row} *
                {{(vtpg_pkg::POS_W){1'b0}}, width};

  assign div_state = (state_r == ST_RSTEP) || (state_r == ST_DSTEP) ||
                     (state_r == ST_RAMP)  || (state_r == ST_DIAG);
  assign div_start = div_state && !launched_r;
  assign take      = div_state && launched_r && div_done;

  always_comb begin
    case (state_r)
      ST_RSTEP: begin
        dvd = vtpg_pkg::DVD_W'(256);
        dvs = width;
      end
      ST_DSTEP: begin
        dvd = {{(vtpg_pkg::DVD_W-vtpg_pkg::DIM_W){1'b0}}, width};
        dvs = height;
      end
      ST_RAMP: begin
        dvd = {{(vtpg_pkg::DVD_W-vtpg_pkg::POS_W-8){1'b0}}, pos.col, 8'h00};
        dvs = width;
      end
      ST_DIAG: begin
        dvd = prod[vtpg_pkg::DVD_W-1:0];
        dvs = height;
      end
      default: begin
        dvd = '0;
        dvs = width;
      end
    endcase
  end

  vtpg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    state_nxt    = state_r;
    launched_nxt = launched_r;
    if (cfg_wr) begin
      state_nxt    = ST_NORM;
      launched_nxt = 1'b0;
    end else begin
      case (state_r)
        ST_NORM:  state_nxt = ST_RSTEP;
        ST_RSTEP,
        ST_DSTEP,
        ST_RAMP,
        ST_DIAG: begin
          if (div_start) begin
            launched_nxt = 1'b1;
          end else if (take) begin
            launched_nxt = 1'b0;
            case (state_r)
              ST_RSTEP: state_nxt = ST_DSTEP;
              ST_DSTEP: state_nxt = ST_RAMP;
              ST_RAMP:  state_nxt = ST_DIAG;
              default:  state_nxt = ST_LOAD;
            endcase
          end
        end
        ST_LOAD:  state_nxt = ST_RUN;
        ST_RUN:   state_nxt = ST_RUN;
        default:  state_nxt = ST_NORM;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_NORM;
      launched_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
    end
  end

  // capture division results
  always_ff @(posedge clk) begin
    if (take) begin
      case (state_r)
        ST_RSTEP: begin
          rs_q_r <= quo[vtpg_pkg::PIX_W-1:0];
          rs_r_r <= rem;
        end
        ST_DSTEP: begin
          ds_q_r <= quo[vtpg_pkg::POS_W-1:0];
          ds_r_r <= rem;
        end
        ST_RAMP: begin
          rq_r <= quo[vtpg_pkg::PIX_W-1:0];
          rr_r <= rem;
        end
        default: begin
          dq_r <= quo[vtpg_pkg::DIM_W-1:0];
          dr_r <= rem;
        end
      endcase
    end
  end

  always_comb begin
    ctrl.busy        = (state_r != ST_RUN);
    ctrl.load        = (state_r == ST_LOAD) && !cfg_wr;
    ctrl.ramp_step_q = rs_q_r;
    ctrl.ramp_step_r = rs_r_r;
    ctrl.diag_step_q = ds_q_r;
    ctrl.diag_step_r = ds_r_r;
    ctrl.ramp_q      = rq_r;
    ctrl.ramp_r      = rr_r;
    ctrl.diag_q      = dq_r;
    ctrl.diag_r      = dr_r;
  end

endmodule

### hdl/vtpg_raster.sv
// ---------------------------------------------------------------------------
// vtpg_raster
// Raster position, ramp and diagonal accumulators, pixel select and output
// register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vtpg_raster (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [vtpg_pkg::DIM_W-1:0]  width,
  input  logic [vtpg_pkg::DIM_W-1:0]  height,
  input  vtpg_pkg::init_ctrl_t        init_i,
  output vtpg_pkg::pos_t              pos,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vtpg_pkg::PIX_W-1:0]  out_luma,
  output logic                        out_line_end,
  output logic                        out_frame_end
);

  localparam int DW = vtpg_pkg::DIM_W;
  localparam int PW = vtpg_pkg::POS_W;
  localparam int XW = vtpg_pkg::PIX_W;

  logic [PW-1:0] col_r, row_r;
  logic [XW-1:0] rq_r;
  logic [DW-1:0] rr_r, dq_r, dr_r;

  logic          out_valid_r;
  logic [XW-1:0] luma_r;
  logic          line_end_r, frame_end_r;

  logic          acc;
  logic [PW-1:0] cur_col, cur_row;
  logic [XW-1:0] cur_rq;
  logic [DW-1:0] cur_rr, cur_dq, cur_dr;
  logic [DW-1:0] col_x, row_x;
  logic [DW-1:0] second_diag;
  logic [PW-1:0] row_m1;
  logic          line_end, frame_end;
  logic          on_diag;
  logic [XW-1:0] luma_nxt;

  logic [DW:0]   rr_sum, rr_sub;
  logic [XW:0]   rq_sum;
  logic [DW:0]   dr_sum, dr_sub;
  logic [DW:0]   dq_sum;
  logic [XW-1:0] rq_nxt;
  logic [DW-1:0] rr_nxt, dq_nxt, dr_nxt;

  logic [DW-1:0] ncol_row;
  logic [DW-1:0] nrow;
  logic [PW-1:0] fold_col, fold_row;

  assign in_ready = !init_i.busy && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;

  // fold a stale position back into a resized frame; the stored position
  // is left as it is until the next pixel is taken
  assign ncol_row = ({1'b0, col_r} >= width) ? ({1'b0, row_r} + 1'b1) : {1'b0, row_r};
  assign nrow     = (ncol_row >= height) ? '0 : ncol_row;
  assign fold_col = ({1'b0, col_r} >= width) ? '0 : col_r;
  assign fold_row = nrow[PW-1:0];

  // restart puts this pixel at the frame origin
  always_comb begin
    if (in_restart) begin
      cur_col = '0;
      cur_row = '0;
      cur_rq  = '0;
      cur_rr  = '0;
      cur_dq  = '0;
      cur_dr  = '0;
    end else begin
      cur_col = fold_col;
      cur_row = fold_row;
      cur_rq  = rq_r;
      cur_rr  = rr_r;
      cur_dq  = dq_r;
      cur_dr  = dr_r;
    end
  end

  assign col_x       = {1'b0, cur_col};
  assign row_x       = {1'b0, cur_row};
  assign row_m1      = cur_row - 1'b1;
  assign second_diag = width - cur_dq - {{(DW-1){1'b0}}, (cur_dr != '0)};
  assign line_end    = (col_x == width - 1'b1);
  assign frame_end   = line_end && (row_x == height - 1'b1);
  assign on_diag     = (cur_row != '0) && ((col_x == cur_dq) || (col_x == second_diag));

  always_comb begin
    if (col_x == {1'b0, width[DW-1:1]}) begin
      luma_nxt = {cur_row[3:0], 4'h0};
    end else if (row_x == {1'b0, height[DW-1:1]}) begin
      luma_nxt = {cur_col[3:0], 4'h0};
    end else if (on_diag) begin
      luma_nxt = {row_m1[3:0], 4'h0};
    end else begin
      luma_nxt = cur_rq;
    end
  end

  // advance ramp by one column and diagonal by one row
  assign rr_sum = {1'b0, cur_rr} + {1'b0, init_i.ramp_step_r};
  assign rq_sum = {1'b0, cur_rq} + {1'b0, init_i.ramp_step_q};
  assign rr_sub = rr_sum - {1'b0, width};
  assign dr_sum = {1'b0, cur_dr} + {1'b0, init_i.diag_step_r};
  assign dq_sum = {1'b0, cur_dq} + {2'b0, init_i.diag_step_q};
  assign dr_sub = dr_sum - {1'b0, height};

  always_comb begin
    if (rr_sum >= {1'b0, width}) begin
      rr_nxt = rr_sub[DW-1:0];
      rq_nxt = rq_sum[XW-1:0] + 1'b1;
    end else begin
      rr_nxt = rr_sum[DW-1:0];
      rq_nxt = rq_sum[XW-1:0];
    end
    if (dr_sum >= {1'b0, height}) begin
      dr_nxt = dr_sub[DW-1:0];
      dq_nxt = dq_sum[DW-1:0] + 1'b1;
    end else begin
      dr_nxt = dr_sum[DW-1:0];
      dq_nxt = dq_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      rq_r  <= '0;
      rr_r  <= '0;
      dq_r  <= '0;
      dr_r  <= '0;
    end else if (init_i.load) begin
      rq_r <= init_i.ramp_q;
      rr_r <= init_i.ramp_r;
      dq_r <= init_i.diag_q;
      dr_r <= init_i.diag_r;
    end else if (acc) begin
      if (line_end) begin
        col_r <= '0;
        rq_r  <= '0;
        rr_r  <= '0;
        if (frame_end) begin
          row_r <= '0;
          dq_r  <= '0;
          dr_r  <= '0;
        end else begin
          row_r <= cur_row + 1'b1;
          dq_r  <= dq_nxt;
          dr_r  <= dr_nxt;
        end
      end else begin
        col_r <= cur_col + 1'b1;
        row_r <= cur_row;
        rq_r  <= rq_nxt;
        rr_r  <= rr_nxt;
        dq_r  <= cur_dq;
        dr_r  <= cur_dr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      luma_r      <= luma_nxt;
      line_end_r  <= line_end;
      frame_end_r <= frame_end;
    end
  end

  assign pos.col       = fold_col;
  assign pos.row       = fold_row;
  assign out_valid     = out_valid_r;
  assign out_luma      = luma_r;
  assign out_line_end  = line_end_r;
  assign out_frame_end = frame_end_r;

  `ASSERT_PROP(a_acc_gives_result, acc |=> out_valid_r)
  `ASSERT_PROP(a_pos_in_frame, ({1'b0, fold_col} < width) && ({1'b0, fold_row} < height))
  `ASSERT_PROP(a_rem_in_range, !init_i.busy |-> (rr_r < width) && (dr_r < height))
  `ASSERT_NEVER(a_frame_without_line, out_valid_r && out_frame_end && !out_line_end)

endmodule

### sim/vtpg_checker.sv
// ---------------------------------------------------------------------------
// vtpg_checker
// Watches the pixel request, pixel and configuration channels of the test
// pattern generator, predicts every pixel from its own raster state and
// compares each transferred pixel field by field, in order.
// ---------------------------------------------------------------------------
module vtpg_checker
  import vtpg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_restart,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [PIX_W-1:0] out_luma,
  input  logic [PIX_W-1:0] out_chroma,
  input  logic             out_line_end,
  input  logic             out_frame_end,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  output int               mismatch_count,
  output int               pixels_pending,
  output int               frame_ends
);

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma;
    logic             line_end;
    logic             frame_end;
  } pixel_t;

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos;
  pixel_t           expected_pixels[$];
  int               errs;
  int               frames;
  int               pixel_no;

  initial begin
    mismatch_count = 0;
    pixels_pending = 0;
    frame_ends     = 0;
    errs           = 0;
    frames         = 0;
    pixel_no       = 0;
  end

  task automatic report(input string msg);
    $display("%0t vtpg_checker: %s", $time, msg);
    errs++;
  endtask

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // Emit the pixel at the current raster position, then advance it.
  function automatic pixel_t raster_pixel(input logic restart);
    int unsigned w, h, c, r, ramp, dq, dr, d2;
    pixel_t      px;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    c = restart ? 0 : col_pos;
    r = restart ? 0 : row_pos;
    // size shrank under the current position
    if (c >= w) begin
      c = 0;
      r = r + 1;
    end
    if (r >= h) r = 0;
    ramp = (c * 256) / w;
    dq   = (r * w) / h;
    dr   = (r * w) % h;
    d2   = w - dq - ((dr != 0) ? 1 : 0);
    px.chroma = CHROMA_VAL;
    if (c == w / 2) px.luma = PIX_W'(16 * r);
    else if (r == h / 2) px.luma = PIX_W'(16 * c);
    else if (r >= 1 && (c == dq || c == d2)) px.luma = PIX_W'(16 * (r - 1));
    else px.luma = PIX_W'(ramp);
    px.line_end  = (c == w - 1);
    px.frame_end = px.line_end && (r == h - 1);
    if (px.line_end) begin
      c = 0;
      r = px.frame_end ? 0 : r + 1;
    end else begin
      c = c + 1;
    end
    col_pos = POS_W'(c);
    row_pos = POS_W'(r);
    return px;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    if (!rst_n) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      col_pos    = '0;
      row_pos    = '0;
      expected_pixels.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{luma: out_luma, chroma: out_chroma, line_end: out_line_end,
                frame_end: out_frame_end};
        pixel_no++;
        if (got.frame_end === 1'b1) frames++;
        if (expected_pixels.size() == 0) begin
          report($sformatf("pixel %0d arrived with none requested", pixel_no));
        end else begin
          want = expected_pixels.pop_front();
          if (got.luma !== want.luma)
            report($sformatf("pixel %0d luma %0d, expected %0d", pixel_no, got.luma,
                             want.luma));
          if (got.chroma !== want.chroma)
            report($sformatf("pixel %0d chroma %0d, expected %0d", pixel_no, got.chroma,
                             want.chroma));
          if (got.line_end !== want.line_end)
            report($sformatf("pixel %0d line_end %b, expected %b", pixel_no, got.line_end,
                             want.line_end));
          if (got.frame_end !== want.frame_end)
            report($sformatf("pixel %0d frame_end %b, expected %b", pixel_no,
                             got.frame_end, want.frame_end));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  width_reg  = cfg_data;
          CFG_HEIGHT: height_reg = cfg_data;
          default:    ;
        endcase
      end
      if (in_valid && in_ready)
        expected_pixels.push_back(raster_pixel(in_restart));
    end
    mismatch_count <= errs;
    pixels_pending <= expected_pixels.size();
    frame_ends     <= frames;
  end

endmodule

### sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the video test pattern generator: resets the block, steps
// it through a series of frame sizes (clamped extremes, mid-frame shrinks,
// many small frames) and requests pixels in random bursts while the pixel
// receiver stalls on its own pattern. The checker beside the block predicts
// and compares every pixel; this module only drives and gives the verdict.
// ---------------------------------------------------------------------------
module tb_top;
  import vtpg_pkg::*;

  // Wait out the setup pass after a size write, with margin.
  localparam int SETUP_WAIT   = 128;
  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_CYCLES  = 16;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic             in_ready;
  logic             in_restart = 1'b0;
  logic             out_valid;
  logic             out_ready  = 1'b0;
  logic [PIX_W-1:0] out_luma;
  logic [PIX_W-1:0] out_chroma;
  logic             out_line_end;
  logic             out_frame_end;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic             cfg_index  = CFG_WIDTH;
  logic [DIM_W-1:0] cfg_data   = '0;

  int mismatch_count;
  int pixels_pending;
  int frame_ends;
  int pixels_requested = 0;
  int size_writes      = 0;
  int ready_mode       = 0;
  int ready_left       = 0;

  always #4 clk = ~clk;

  video_test_pattern_generator_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_luma      (out_luma),
    .out_chroma    (out_chroma),
    .out_line_end  (out_line_end),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  vtpg_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_luma       (out_luma),
    .out_chroma     (out_chroma),
    .out_line_end   (out_line_end),
    .out_frame_end  (out_frame_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pixels_pending (pixels_pending),
    .frame_ends     (frame_ends)
  );

  // Pixel receiver: switch at random between always ready,
  // mostly ready, mostly stalled and a fixed 5-of-8 duty pattern.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(20, 80);
    end
    ready_left--;
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((ready_left % 8) < 5);
    endcase
  end

  // Present one pixel request and hold it until the transfer. Valid is left
  // high so a following request in the same burst goes out back to back.
  task automatic request_pixel(input logic restart);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    pixels_requested++;
  endtask

  // Drop valid and idle for the given gap.
  task automatic pause_requests(input int gap);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Directed burst: restart flags taken from the low bits, first item first.
  task automatic request_seq(input logic [31:0] restarts, input int n);
    for (int i = 0; i < n; i++) request_pixel(restarts[i]);
    pause_requests(1);
  endtask

  // Random run of n requests in bursts; a quarter of runs go without gaps.
  task automatic request_run(input int n);
    int  left;
    int  burst;
    bit  gapless;
    left    = n;
    gapless = ($urandom_range(0, 3) == 0);
    while (left > 0) begin
      burst = gapless ? left : $urandom_range(1, 10);
      if (burst > left) burst = left;
      for (int i = 0; i < burst; i++) request_pixel($urandom_range(0, 39) == 0);
      left -= burst;
      pause_requests(gapless ? 1 : $urandom_range(1, 6));
    end
  endtask

  // Write one size register with the block idle: drain all pixels first,
  // then hold off while the setup pass recomputes its step values.
  task automatic write_size(input logic idx, input logic [DIM_W-1:0] val);
    while (pixels_pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_writes++;
    repeat (SETUP_WAIT) @(posedge clk);
  endtask

  initial begin
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    int               pick;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size 352 x 288: restart at the origin, then one more pixel.
    request_seq(32'b01, 2);

    // Zero and one clamp to 2 x 2: the column is past the new width, so the
    // line restarts; cover line and frame ends and both center lines.
    write_size(CFG_WIDTH, 11'd0);
    write_size(CFG_HEIGHT, 11'd1);
    request_seq(32'b0, 5);

    // All-ones width and just past the maximum height clamp to 1024.
    write_size(CFG_WIDTH, 11'd2047);
    write_size(CFG_HEIGHT, 11'd1025);
    request_seq(32'b01, 2);

    // 8 x 6 frame from the origin, into the second row and its diagonals.
    write_size(CFG_WIDTH, 11'd8);
    write_size(CFG_HEIGHT, 11'd6);
    request_seq(32'b1, 10);

    // Shrink the width under the position, then the height under the row.
    write_size(CFG_WIDTH, 11'd2);
    request_seq(32'b0, 2);
    write_size(CFG_HEIGHT, 11'd2);
    request_seq(32'b0, 1);

    // Random part: mostly small frames so whole frames wrap many times,
    // some full-width frames and some raw register values out of range.
    // Each new setting drains the pipe first, so the sender waits for
    // every outstanding pixel at least once per phase.
    pixels_requested = 0;
    while (pixels_requested < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        w = DIM_W'($urandom_range(0, 2047));
        h = DIM_W'($urandom_range(0, 2047));
      end else if (pick == 1) begin
        w = DIM_W'(MAX_WIDTH);
        h = DIM_W'($urandom_range(2, 6));
      end else if (pick == 2) begin
        w = DIM_W'($urandom_range(2, 6));
        h = DIM_W'(MAX_HEIGHT);
      end else begin
        w = DIM_W'($urandom_range(2, 16));
        h = DIM_W'($urandom_range(2, 12));
      end
      // keep one register now and then so the other changes alone
      if ($urandom_range(0, 3) != 0) write_size(CFG_WIDTH, w);
      if ($urandom_range(0, 3) != 0) write_size(CFG_HEIGHT, h);
      request_run($urandom_range(16, 64));
    end

    // Let every requested pixel come back, then idle for TAIL_CYCLES
    // and watch for anything extra.
    while (pixels_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d random pixel requests after the directed set, %0d size writes,",
             pixels_requested, size_writes);
    $display("summary: %0d frame ends observed, %0d mismatches", frame_ends, mismatch_count);
    if (mismatch_count == 0 && pixels_pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
